@@ hw/rtl/cfm_pkg.sv @@
`default_nettype none
package cfm_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [15:0] COUNTER_PERIOD_RESET = 16'd65535;
   localparam logic [31:0] REF_CLOCK_HZ_RESET = 32'd1000000;
   localparam logic [15:0] DEBOUNCE_MIN_RESET = 16'd10;
   localparam logic LEVEL_MODE_RESET = 1'b1;

   localparam logic [15:0] FREQ_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      REG_COUNTER_PERIOD,
      REG_REF_CLOCK_HZ,
      REG_DEBOUNCE_MIN,
      REG_LEVEL_MODE
   } reg_index_type;

   typedef struct packed {
      logic [15:0] counter_period;
      logic [31:0] ref_clock_hz;
      logic [15:0] debounce_min;
      logic level_mode;
   } cfg_type;

   typedef struct packed {
      logic [16:0] divisor;
      logic [15:0] high_ticks;
      logic [15:0] low_ticks;
   } job_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

endpackage
`default_nettype wire

@@ hw/rtl/cfm_csr.sv @@
`default_nettype none
module cfm_csr (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [cfm_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cfm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cfm_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready,
   output cfm_pkg::cfg_type cfg
);
   import cfm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_index_type index;
   logic write_en;

   assign index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_COUNTER_PERIOD: cfg_in.counter_period = pwdata[15:0];
            REG_REF_CLOCK_HZ:   cfg_in.ref_clock_hz = pwdata[31:0];
            REG_DEBOUNCE_MIN:   cfg_in.debounce_min = pwdata[15:0];
            REG_LEVEL_MODE:     cfg_in.level_mode = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_COUNTER_PERIOD: prdata = {16'd0, cfg_ff.counter_period};
         REG_REF_CLOCK_HZ:   prdata = cfg_ff.ref_clock_hz;
         REG_DEBOUNCE_MIN:   prdata = {16'd0, cfg_ff.debounce_min};
         REG_LEVEL_MODE:     prdata = {31'd0, cfg_ff.level_mode};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counter_period <= COUNTER_PERIOD_RESET;
         cfg_ff.ref_clock_hz <= REF_CLOCK_HZ_RESET;
         cfg_ff.debounce_min <= DEBOUNCE_MIN_RESET;
         cfg_ff.level_mode <= LEVEL_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/cfm_front.sv @@
`default_nettype none
module cfm_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire cfm_pkg::cfg_type cfg,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [15:0] req_capture_value,
   input  wire logic req_pin_level,
   input  wire logic queue_full,
   output logic push,
   output cfm_pkg::job_type push_job
);
   import cfm_pkg::*;

   logic [15:0] previous_capture_ff, previous_capture_in;
   logic [15:0] high_time_ff, high_time_in;
   logic [15:0] low_time_ff, low_time_in;
   logic [15:0] distance;
   logic accept;
   logic keep;

   assign req_ready = ~queue_full;
   assign accept = req_valid & req_ready;

   // The counter wraps at period + 1; both branches are taken modulo 2^16.
   always_comb begin
      if (previous_capture_ff > req_capture_value) begin
         distance = cfg.counter_period - previous_capture_ff + req_capture_value + 16'd1;
      end else begin
         distance = req_capture_value - previous_capture_ff;
      end
   end

   assign keep = distance >= cfg.debounce_min;
   assign push = accept & keep;

   always_comb begin
      previous_capture_in = previous_capture_ff;
      high_time_in = high_time_ff;
      low_time_in = low_time_ff;
      if (push) begin
         previous_capture_in = req_capture_value;
         if (cfg.level_mode) begin
            if (req_pin_level) begin
               low_time_in = distance;
            end else begin
               high_time_in = distance;
            end
         end
      end
   end

   always_comb begin
      push_job.high_ticks = high_time_in;
      push_job.low_ticks = low_time_in;
      if (cfg.level_mode) begin
         push_job.divisor = {1'b0, high_time_in} + {1'b0, low_time_in};
      end else begin
         push_job.divisor = {distance, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_capture_ff <= '0;
         high_time_ff <= '0;
         low_time_ff <= '0;
      end else begin
         previous_capture_ff <= previous_capture_in;
         high_time_ff <= high_time_in;
         low_time_ff <= low_time_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/cfm_queue.sv @@
`default_nettype none
module cfm_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire cfm_pkg::job_type push_job,
   output logic full,
   input  wire logic pop,
   output cfm_pkg::job_type pop_job,
   output logic empty
);
   import cfm_pkg::*;

   job_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/cfm_div.sv @@
`default_nettype none
module cfm_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [31:0] ref_clock_hz,
   input  wire logic queue_empty,
   input  wire cfm_pkg::job_type pop_job,
   output logic pop,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [15:0] rsp_frequency,
   output logic [15:0] rsp_high_ticks,
   output logic [15:0] rsp_low_ticks
);
   import cfm_pkg::*;

   div_state_type state_ff, state_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [31:0] num_ff, num_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] den_ff, den_in;
   logic [15:0] freq_ff, freq_in;
   logic [15:0] high_ff, high_in;
   logic [15:0] low_ff, low_in;
   logic [17:0] rem_shift;
   logic [17:0] rem_diff;
   logic fits;
   logic [31:0] quotient;

   // One restoring step per cycle; the dividend shifts out as quotient bits shift in.
   // A zero divisor yields an all-ones quotient, which saturates as required.
   assign rem_shift = {rem_ff, num_ff[31]};
   assign rem_diff = rem_shift - {1'b0, den_ff};
   assign fits = rem_shift >= {1'b0, den_ff};
   assign quotient = {num_ff[30:0], fits};

   assign rsp_valid = state_ff == DIV_HOLD;
   assign rsp_frequency = freq_ff;
   assign rsp_high_ticks = high_ff;
   assign rsp_low_ticks = low_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      freq_in = freq_ff;
      high_in = high_ff;
      low_in = low_ff;
      pop = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               num_in = ref_clock_hz;
               rem_in = '0;
               den_in = pop_job.divisor;
               high_in = pop_job.high_ticks;
               low_in = pop_job.low_ticks;
               count_in = '0;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            num_in = quotient;
            rem_in = fits ? rem_diff[16:0] : rem_shift[16:0];
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               freq_in = (|quotient[31:16]) ? FREQ_MAX : quotient[15:0];
               state_in = DIV_HOLD;
            end
         end
         DIV_HOLD: begin
            if (rsp_ready) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      freq_ff <= freq_in;
      high_ff <= high_in;
      low_ff <= low_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/capture_frequency_meter.sv @@
`default_nettype none
// Channel   Direction  Handshake                    Payload
// req       in         req_valid / req_ready        req_capture_value, req_pin_level
// rsp       out        rsp_valid / rsp_ready        rsp_frequency, rsp_high_ticks, rsp_low_ticks
// csr       in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// The distance, debounce check and state update of a capture beat happen at acceptance,
// so a rejected beat produces nothing. Kept beats enter a two-entry queue.
// The serial divider works on one result at a time (a load, 32 quotient bits and a hold
// until rsp is taken), and that divider sets the sustained rate. Reset is synchronous and
// restores the register defaults and clears the stored capture and phase times. A stalled
// rsp holds the divider; the front keeps taking beats until the queue fills.
module capture_frequency_meter (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [15:0] req_capture_value,
   input  wire logic req_pin_level,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [15:0] rsp_frequency,
   output logic [15:0] rsp_high_ticks,
   output logic [15:0] rsp_low_ticks,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [cfm_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cfm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cfm_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);
   import cfm_pkg::*;

   cfg_type cfg;
   logic push;
   logic pop;
   logic queue_full;
   logic queue_empty;
   job_type push_job;
   job_type pop_job;

   cfm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cfm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_capture_value (req_capture_value),
      .req_pin_level     (req_pin_level),
      .queue_full        (queue_full),
      .push              (push),
      .push_job          (push_job)
   );

   cfm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   cfm_div u_div (
      .clock          (clock),
      .reset          (reset),
      .ref_clock_hz   (cfg.ref_clock_hz),
      .queue_empty    (queue_empty),
      .pop_job        (pop_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frequency  (rsp_frequency),
      .rsp_high_ticks (rsp_high_ticks),
      .rsp_low_ticks  (rsp_low_ticks)
   );

endmodule
`default_nettype wire
